@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the line assembler checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MLAF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property violated");

// expression must never be true outside reset
`define MLAF_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`endif

@@ design/mlaf_pkg.sv @@
// ----------------------------------------------------------------------------
// mlaf_pkg
// Types, codes and default sizes shared by the multichannel line assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlaf_pkg;

	// default sizes
	localparam int LINE_LIMIT_DEF = 63;
	localparam int FIFO_DEPTH_DEF = 8;
	localparam int CHANNELS_DEF   = 4;

	// fixed field widths of the transaction ports
	localparam int CHAN_W     = 2;
	localparam int CHAR_W     = 8;
	localparam int KIND_W     = 3;
	localparam int OUT_LEN_W  = 6;
	localparam int QUEUED_W   = 4;
	localparam int DROP_W     = 16;

	localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

	// special characters
	localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;

	// item modes
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_STORED  = 3'd0,
		KIND_TRUNC   = 3'd1,
		KIND_CR      = 3'd2,
		KIND_QUEUED  = 3'd3,
		KIND_DROPPED = 3'd4,
		KIND_CHAR    = 3'd5,
		KIND_EMPTY   = 3'd6
	} kind_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_POP
	} state_t;

	// write strobes towards the line store
	typedef struct packed {
		logic asm_we;
		logic q_we;
		logic len_we;
	} mem_ctl_t;

endpackage

`default_nettype wire

@@ design/mlaf_line_store.sv @@
// ----------------------------------------------------------------------------
// mlaf_line_store
// Character and length memories: lines under assembly, queued lines and
// queued line lengths. All reads are registered; queued characters are
// written straight from the assembly read port during a line copy.
// ----------------------------------------------------------------------------
`default_nettype none

module mlaf_line_store #(
	parameter int CH_W   = 2,
	parameter int SLOT_W = 3,
	parameter int IDX_W  = 6,
	parameter int LEN_W  = 6
) (
	input  wire                                  clk,
	input  mlaf_pkg::mem_ctl_t                   ctl,
	input  wire  [CH_W+IDX_W-1:0]                asm_waddr,
	input  wire  [mlaf_pkg::CHAR_W-1:0]          asm_wdata,
	input  wire  [CH_W+IDX_W-1:0]                asm_raddr,
	input  wire  [CH_W+SLOT_W+IDX_W-1:0]         q_waddr,
	input  wire  [CH_W+SLOT_W+IDX_W-1:0]         q_raddr,
	output logic [mlaf_pkg::CHAR_W-1:0]          q_rdata,
	input  wire  [CH_W+SLOT_W-1:0]               len_waddr,
	input  wire  [LEN_W-1:0]                     len_wdata,
	input  wire  [CH_W+SLOT_W-1:0]               len_raddr,
	output logic [LEN_W-1:0]                     len_rdata
);

	localparam int ASM_AW = CH_W + IDX_W;
	localparam int Q_AW   = CH_W + SLOT_W + IDX_W;
	localparam int LEN_AW = CH_W + SLOT_W;

	logic [mlaf_pkg::CHAR_W-1:0] asm_mem [2**ASM_AW];
	logic [mlaf_pkg::CHAR_W-1:0] q_mem   [2**Q_AW];
	logic [LEN_W-1:0]            len_mem [2**LEN_AW];

	logic [mlaf_pkg::CHAR_W-1:0] asm_rdata_q;

	// lines under assembly
	always_ff @(posedge clk) begin
		if (ctl.asm_we) begin
			asm_mem[asm_waddr] <= asm_wdata;
		end
		asm_rdata_q <= asm_mem[asm_raddr];
	end

	// queued line characters, filled from the assembly read port
	always_ff @(posedge clk) begin
		if (ctl.q_we) begin
			q_mem[q_waddr] <= asm_rdata_q;
		end
		q_rdata <= q_mem[q_raddr];
	end

	// queued line lengths
	always_ff @(posedge clk) begin
		if (ctl.len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		len_rdata <= len_mem[len_raddr];
	end

endmodule

`default_nettype wire

@@ design/multichannel_line_assembler_fifo.sv @@
// ----------------------------------------------------------------------------
// multichannel_line_assembler_fifo
// Per-channel receive line framer with a line queue for each channel.
// ----------------------------------------------------------------------------
// Usage
//   Input: a command is taken at a rising edge with start high and busy low.
//   mode 0 hands one received byte of a channel: LF queues the current line
//   (or drops it and bumps the saturating drop count if the queue is full),
//   CR is skipped, anything else is appended up to LINE_LIMIT characters.
//   mode 1 pops the oldest queued line of the channel.
//   Output: each result shows for one cycle with result_valid high; last marks
//   the final result of a command. The receiver cannot stall the block.
//   Timing: a byte that is not LF, an LF on an empty line or a full queue and
//   a pop of an empty queue give their result the cycle after acceptance;
//   busy stays low, so such commands may follow every cycle.
//   An LF on a line of n characters copies the line from the assembly memory
//   to the queue memory one character per cycle (single write port); busy
//   stays high during the copy and the result follows its last character.
//   A pop of a line of n characters reads the queue memory one character per
//   cycle and gives one result per character (one result for an empty line);
//   busy stays high until the last character has been read.
//   Commands on a channel at or beyond CHANNELS are ignored.
//   Reset clears all line lengths, queue pointers, fill and drop counts; the
//   character memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_line_assembler_fifo #(
	parameter int LINE_LIMIT = mlaf_pkg::LINE_LIMIT_DEF,
	parameter int FIFO_DEPTH = mlaf_pkg::FIFO_DEPTH_DEF,
	parameter int CHANNELS   = mlaf_pkg::CHANNELS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire                              mode,
	input  wire  [mlaf_pkg::CHAN_W-1:0]      channel,
	input  wire  [mlaf_pkg::CHAR_W-1:0]      data_byte,
	output logic                             result_valid,
	output logic [mlaf_pkg::KIND_W-1:0]      result_kind,
	output logic [mlaf_pkg::CHAR_W-1:0]      out_char,
	output logic [mlaf_pkg::OUT_LEN_W-1:0]   line_length,
	output logic                             last,
	output logic [mlaf_pkg::QUEUED_W-1:0]    queued_lines,
	output logic [mlaf_pkg::DROP_W-1:0]      dropped_lines
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W = $clog2(FIFO_DEPTH);
	localparam int IDX_W  = (LINE_LIMIT > 1) ? $clog2(LINE_LIMIT) : 1;
	localparam int LEN_W  = $clog2(LINE_LIMIT + 1);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
	localparam int DROP_W = mlaf_pkg::DROP_W;
	localparam int CHAR_W = mlaf_pkg::CHAR_W;

	localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(FIFO_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(FIFO_DEPTH);
	localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(LINE_LIMIT);
	localparam logic [LEN_W-1:0]  LEN_ONE    = LEN_W'(1);

	// per-channel status registers
	logic [LEN_W-1:0]  asm_len_q [CHANNELS];
	logic [SLOT_W-1:0] rd_ptr_q  [CHANNELS];
	logic [SLOT_W-1:0] wr_ptr_q  [CHANNELS];
	logic [FILL_W-1:0] fill_q    [CHANNELS];
	logic [DROP_W-1:0] drop_q    [CHANNELS];

	// sequencer
	mlaf_pkg::state_t state_q, state_d;

	// registers of the command in progress
	logic [CH_W-1:0]   ch_q;
	logic [SLOT_W-1:0] slot_q;
	logic [LEN_W-1:0]  len_q;
	logic [IDX_W-1:0]  idx_q;
	logic [FILL_W-1:0] fill_hold_q;
	logic [DROP_W-1:0] drop_hold_q;

	// result register
	logic                  res_valid_q;
	mlaf_pkg::kind_t       res_kind_q;
	logic [CHAR_W-1:0]     res_char_q;
	logic [LEN_W-1:0]      res_len_q;
	logic                  res_last_q;
	logic [FILL_W-1:0]     res_fill_q;
	logic [DROP_W-1:0]     res_drop_q;

	// combinational decisions
	logic                  accept;
	logic                  chan_ok;
	logic [CH_W-1:0]       chan_idx;
	logic [LEN_W-1:0]      cur_len;
	logic [SLOT_W-1:0]     cur_rd;
	logic [SLOT_W-1:0]     cur_wr;
	logic [FILL_W-1:0]     cur_fill;
	logic [DROP_W-1:0]     cur_drop;
	logic [IDX_W-1:0]      idx_inc;
	logic [LEN_W-1:0]      pop_len;
	logic                  pop_last;
	logic                  copy_last;

	logic                  chan_we;
	logic                  load_op;
	logic [LEN_W-1:0]      len_new;
	logic [SLOT_W-1:0]     rd_new;
	logic [SLOT_W-1:0]     wr_new;
	logic [FILL_W-1:0]     fill_new;
	logic [DROP_W-1:0]     drop_new;

	logic                  res_valid_d;
	mlaf_pkg::kind_t       res_kind_d;
	logic [CHAR_W-1:0]     res_char_d;
	logic [LEN_W-1:0]      res_len_d;
	logic                  res_last_d;
	logic [FILL_W-1:0]     res_fill_d;
	logic [DROP_W-1:0]     res_drop_d;

	// memory interface
	mlaf_pkg::mem_ctl_t              ctl;
	logic [CH_W+IDX_W-1:0]           asm_waddr;
	logic [CH_W+IDX_W-1:0]           asm_raddr;
	logic [CH_W+SLOT_W+IDX_W-1:0]    q_waddr;
	logic [CH_W+SLOT_W+IDX_W-1:0]    q_raddr;
	logic [CHAR_W-1:0]               q_rdata;
	logic [CH_W+SLOT_W-1:0]          len_waddr;
	logic [CH_W+SLOT_W-1:0]          len_raddr;
	logic [LEN_W-1:0]                len_rdata;

	// command decode and channel status lookup
	assign busy     = (state_q != mlaf_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign chan_ok  = (int'(channel) < CHANNELS);
	assign chan_idx = CH_W'(channel);
	assign cur_len  = asm_len_q[chan_idx];
	assign cur_rd   = rd_ptr_q[chan_idx];
	assign cur_wr   = wr_ptr_q[chan_idx];
	assign cur_fill = fill_q[chan_idx];
	assign cur_drop = drop_q[chan_idx];

	// line walk helpers
	assign idx_inc   = idx_q + IDX_W'(1);
	assign pop_len   = (idx_q == '0) ? len_rdata : len_q;
	assign pop_last  = (pop_len == '0) || (LEN_W'(idx_q) == pop_len - LEN_ONE);
	assign copy_last = (LEN_W'(idx_q) == len_q - LEN_ONE);

	// memory addresses
	assign asm_waddr = {chan_idx, IDX_W'(cur_len)};
	assign q_waddr   = {ch_q, slot_q, idx_q};
	assign len_waddr = {chan_idx, cur_wr};
	assign len_raddr = {chan_idx, cur_rd};

	// next state, memory strobes, channel updates and result
	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		chan_we     = 1'b0;
		load_op     = 1'b0;
		len_new     = cur_len;
		rd_new      = cur_rd;
		wr_new      = cur_wr;
		fill_new    = cur_fill;
		drop_new    = cur_drop;
		asm_raddr   = {ch_q, idx_inc};
		q_raddr     = {ch_q, slot_q, idx_inc};
		res_valid_d = 1'b0;
		res_kind_d  = mlaf_pkg::KIND_STORED;
		res_char_d  = '0;
		res_len_d   = '0;
		res_last_d  = 1'b1;
		res_fill_d  = fill_hold_q;
		res_drop_d  = drop_hold_q;

		case (state_q)
			mlaf_pkg::ST_IDLE: begin
				asm_raddr = {chan_idx, {IDX_W{1'b0}}};
				q_raddr   = {chan_idx, cur_rd, {IDX_W{1'b0}}};
				if (accept && chan_ok) begin
					chan_we     = 1'b1;
					res_valid_d = 1'b1;
					if (mode == mlaf_pkg::MODE_POP) begin
						if (cur_fill == '0) begin
							res_kind_d = mlaf_pkg::KIND_EMPTY;
						end else begin
							rd_new      = (cur_rd == SLOT_LAST) ? '0 : cur_rd + SLOT_W'(1);
							fill_new    = cur_fill - FILL_W'(1);
							load_op     = 1'b1;
							res_valid_d = 1'b0;
							state_d     = mlaf_pkg::ST_POP;
						end
					end else if (data_byte == mlaf_pkg::CHAR_LF) begin
						len_new = '0;
						if (cur_fill < FILL_FULL) begin
							ctl.len_we = 1'b1;
							wr_new     = (cur_wr == SLOT_LAST) ? '0 : cur_wr + SLOT_W'(1);
							fill_new   = cur_fill + FILL_W'(1);
							res_kind_d = mlaf_pkg::KIND_QUEUED;
							// non-empty line: copy it over before reporting
							if (cur_len != '0) begin
								load_op     = 1'b1;
								res_valid_d = 1'b0;
								state_d     = mlaf_pkg::ST_COPY;
							end
						end else begin
							if (cur_drop != mlaf_pkg::DROP_MAX) begin
								drop_new = cur_drop + DROP_W'(1);
							end
							res_kind_d = mlaf_pkg::KIND_DROPPED;
						end
					end else if (data_byte == mlaf_pkg::CHAR_CR) begin
						res_kind_d = mlaf_pkg::KIND_CR;
					end else if (cur_len < LEN_LIMIT) begin
						ctl.asm_we = 1'b1;
						len_new    = cur_len + LEN_ONE;
						res_kind_d = mlaf_pkg::KIND_STORED;
					end else begin
						res_kind_d = mlaf_pkg::KIND_TRUNC;
					end
					if (mode == mlaf_pkg::MODE_BYTE) begin
						res_len_d = len_new;
					end
					res_fill_d = fill_new;
					res_drop_d = drop_new;
				end
			end

			mlaf_pkg::ST_COPY: begin
				ctl.q_we = 1'b1;
				if (copy_last) begin
					res_valid_d = 1'b1;
					res_kind_d  = mlaf_pkg::KIND_QUEUED;
					state_d     = mlaf_pkg::ST_IDLE;
				end
			end

			mlaf_pkg::ST_POP: begin
				res_valid_d = 1'b1;
				res_kind_d  = mlaf_pkg::KIND_CHAR;
				res_char_d  = (pop_len == '0) ? '0 : q_rdata;
				res_len_d   = pop_len;
				res_last_d  = pop_last;
				if (pop_last) begin
					state_d = mlaf_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = mlaf_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlaf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-channel status update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				asm_len_q[i] <= '0;
				rd_ptr_q[i]  <= '0;
				wr_ptr_q[i]  <= '0;
				fill_q[i]    <= '0;
				drop_q[i]    <= '0;
			end
		end else if (chan_we) begin
			asm_len_q[chan_idx] <= len_new;
			rd_ptr_q[chan_idx]  <= rd_new;
			wr_ptr_q[chan_idx]  <= wr_new;
			fill_q[chan_idx]    <= fill_new;
			drop_q[chan_idx]    <= drop_new;
		end
	end

	// transaction in progress: channel, slot, length, character index and held fill and drop counts
	always_ff @(posedge clk) begin
		if (load_op) begin
			ch_q        <= chan_idx;
			slot_q      <= (mode == mlaf_pkg::MODE_POP) ? cur_rd : cur_wr;
			len_q       <= cur_len;
			idx_q       <= '0;
			fill_hold_q <= fill_new;
			drop_hold_q <= drop_new;
		end else if (state_q != mlaf_pkg::ST_IDLE) begin
			idx_q <= idx_inc;
			if (state_q == mlaf_pkg::ST_POP) begin
				len_q <= pop_len;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_valid_d;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_valid_d) begin
			res_kind_q <= res_kind_d;
			res_char_q <= res_char_d;
			res_len_q  <= res_len_d;
			res_last_q <= res_last_d;
			res_fill_q <= res_fill_d;
			res_drop_q <= res_drop_d;
		end
	end

	assign result_valid  = res_valid_q;
	assign result_kind   = res_kind_q;
	assign out_char      = res_char_q;
	assign line_length   = mlaf_pkg::OUT_LEN_W'(res_len_q);
	assign last          = res_last_q;
	assign queued_lines  = mlaf_pkg::QUEUED_W'(res_fill_q);
	assign dropped_lines = res_drop_q;

	// character and length memories
	mlaf_line_store #(
		.CH_W   (CH_W),
		.SLOT_W (SLOT_W),
		.IDX_W  (IDX_W),
		.LEN_W  (LEN_W)
	) u_line_store (
		.clk       (clk),
		.ctl       (ctl),
		.asm_waddr (asm_waddr),
		.asm_wdata (data_byte),
		.asm_raddr (asm_raddr),
		.q_waddr   (q_waddr),
		.q_raddr   (q_raddr),
		.q_rdata   (q_rdata),
		.len_waddr (len_waddr),
		.len_wdata (cur_len),
		.len_raddr (len_raddr),
		.len_rdata (len_rdata)
	);

endmodule

`default_nettype wire

@@ design/mlaf_checker.sv @@
// ----------------------------------------------------------------------------
// mlaf_checker
// Port-level checks of the line assembler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mlaf_checker #(
	parameter int CHANNELS = mlaf_pkg::CHANNELS_DEF
) (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             start,
	input wire                             busy,
	input wire                             mode,
	input wire [mlaf_pkg::CHAN_W-1:0]      channel,
	input wire [mlaf_pkg::CHAR_W-1:0]      data_byte,
	input wire                             result_valid,
	input wire [mlaf_pkg::KIND_W-1:0]      result_kind,
	input wire [mlaf_pkg::CHAR_W-1:0]      out_char,
	input wire [mlaf_pkg::OUT_LEN_W-1:0]   line_length,
	input wire                             last
);

	logic plain_byte;
	logic mid_result;
	logic empty_nonzero;

	// accepted byte transaction that is not a line end on a live channel
	assign plain_byte = start && !busy && (mode == mlaf_pkg::MODE_BYTE)
		&& (data_byte != mlaf_pkg::CHAR_LF) && (int'(channel) < CHANNELS);

	// result without the last marker
	assign mid_result = result_valid && !last;

	// queue-empty result carrying a character or a length
	assign empty_nonzero = result_valid && (result_kind == mlaf_pkg::KIND_EMPTY)
		&& ((out_char != '0) || (line_length != '0));

	// a popped line streams without gaps
	`MLAF_ASSERT(a_line_contiguous, clk, arst_n, mid_result |=> result_valid)

	// more characters pending means the block is still busy
	`MLAF_ASSERT(a_busy_mid_line, clk, arst_n, mid_result |-> busy)

	// only line characters may come without the last marker
	`MLAF_NEVER(a_single_result, clk, arst_n, mid_result && (result_kind != mlaf_pkg::KIND_CHAR))

	// an empty queue reports no character and no length
	`MLAF_NEVER(a_empty_zero, clk, arst_n, empty_nonzero)

	// ordinary bytes are answered in the next cycle
	`MLAF_ASSERT(a_byte_latency, clk, arst_n, plain_byte |=> result_valid && last)

endmodule

bind multichannel_line_assembler_fifo mlaf_checker #(
	.CHANNELS (CHANNELS)
) u_mlaf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.mode         (mode),
	.channel      (channel),
	.data_byte    (data_byte),
	.result_valid (result_valid),
	.result_kind  (result_kind),
	.out_char     (out_char),
	.line_length  (line_length),
	.last         (last)
);

`default_nettype wire
